FILE: hdl/text_console_char_writer_assert.svh
// Assertion macros used by the console writer controller
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// Checked only while out of reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Control character codes
  localparam logic [7:0] NL_CODE = 8'd10;
  localparam logic [7:0] CR_CODE = 8'd13;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int IDX_W       = 11;
  localparam int COL_O_W     = 7;
  localparam int ROW_O_W     = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Screen memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } tcw_mem_ctl_t;

endpackage

FILE: hdl/tcw_screen_mem.sv
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  tcw_pkg::tcw_mem_ctl_t      ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] cells_r [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      cells_r[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= cells_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tcw_ctrl.sv
`include "text_console_char_writer_assert.svh"

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int AW      = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]                      out_tuser,
  output tcw_pkg::tcw_mem_ctl_t           mem_ctl,
  output logic [AW-1:0]                   mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]      mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]      mem_rdata
);
  import tcw_pkg::*;

  localparam int CW        = $clog2(COLUMNS + 1);
  localparam int RW        = $clog2(ROWS + 1);
  localparam int NCELLS    = ROWS * COLUMNS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                 out_wr_r, out_wr_nxt;
  logic                 pend_we_r, pend_we_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [CELL_W-1:0]    pend_cell_r, pend_cell_nxt;
  logic                 copy_we_r, copy_we_nxt;
  logic [AW-1:0]        cp_wa_r, cp_wa_nxt;

  logic                 in_acc;
  logic [CHAR_W-1:0]    ch, at;
  logic                 wrap, scr, is_nl, is_cr, do_wr;
  logic [CW-1:0]        c1, col_step;
  logic [RW-1:0]        r1, r2, row_step;
  logic [AW-1:0]        pos;
  logic [31:0]          idx32, col32, row32;
  logic                 cnt_last;

  assign ch        = in_tdata[CHAR_W-1:0];
  assign at        = in_tdata[2*CHAR_W-1:CHAR_W];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cnt_last  = (cnt_r == AW'(NCELLS - 1));

  // Resolve pending wrap and scroll, then apply the character
  always_comb begin
    wrap     = (col_r == CW'(COLUMNS));
    c1       = wrap ? '0 : col_r;
    r1       = wrap ? row_r + RW'(1) : row_r;
    scr      = (r1 == RW'(ROWS));
    r2       = scr ? RW'(ROWS - 1) : r1;
    pos      = AW'(r2) * AW'(COLUMNS) + AW'(c1);
    is_nl    = (ch == NL_CODE);
    is_cr    = (ch == CR_CODE);
    do_wr    = !is_nl && !is_cr;
    col_step = c1;
    row_step = r2;
    if (is_nl) begin
      row_step = r2 + RW'(1);
    end else if (is_cr) begin
      col_step = '0;
    end else if (ch != '0) begin
      col_step = c1 + CW'(1);
    end
    idx32 = do_wr ? 32'(pos) : '0;
    col32 = 32'(col_step);
    row32 = 32'(row_step);
  end

  // Sequencer: clearing pass, item handling, scroll copy and bottom row fill
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_wr_nxt    = out_wr_r;
    pend_we_nxt   = pend_we_r;
    pend_idx_nxt  = pend_idx_r;
    pend_cell_nxt = pend_cell_r;
    copy_we_nxt   = (state_r == ST_SCROLL);
    cp_wa_nxt     = cnt_r - AW'(COLUMNS);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          col_nxt       = col_step;
          row_nxt       = row_step;
          out_valid_nxt = 1'b1;
          out_wr_nxt    = do_wr;
          out_data_nxt  = {row32[ROW_O_W-1:0], col32[COL_O_W-1:0], scr,
                           do_wr ? at : 8'h00, do_wr ? ch : 8'h00, idx32[IDX_W-1:0]};
          if (scr) begin
            state_nxt     = ST_SCROLL;
            cnt_nxt       = AW'(COLUMNS);
            pend_we_nxt   = do_wr;
            pend_idx_nxt  = pos;
            pend_cell_nxt = {at, ch};
          end
        end
      end
      ST_SCROLL: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_last) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = AW'(LAST_BASE);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory port drive; the delayed copy write has the port to itself
  always_comb begin
    mem_ctl.re = (state_r == ST_SCROLL);
    mem_ctl.we = 1'b0;
    mem_raddr  = cnt_r;
    mem_waddr  = cnt_r;
    mem_wdata  = '0;
    if (copy_we_r) begin
      mem_ctl.we = 1'b1;
      mem_waddr  = cp_wa_r;
      mem_wdata  = mem_rdata;
    end else begin
      case (state_r)
        ST_CLEAR: mem_ctl.we = 1'b1;
        ST_FILL: begin
          mem_ctl.we = 1'b1;
          if (pend_we_r && (cnt_r == pend_idx_r)) begin
            mem_wdata = pend_cell_r;
          end
        end
        ST_IDLE: begin
          mem_ctl.we = in_acc && do_wr && !scr;
          mem_waddr  = pos;
          mem_wdata  = {at, ch};
        end
        default: mem_ctl.we = 1'b0;
      endcase
    end
  end

  // State, cursor and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      copy_we_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      copy_we_r   <= copy_we_nxt;
      out_data_r  <= out_data_nxt;
      out_wr_r    <= out_wr_nxt;
      pend_we_r   <= pend_we_nxt;
      pend_idx_r  <= pend_idx_nxt;
      pend_cell_r <= pend_cell_nxt;
      cp_wa_r     <= cp_wa_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_wr_r;

  // Checks
  `TCW_ASSERT(a_scroll_entry, (in_acc && scr) |=> (state_r == ST_SCROLL), "scroll not started")
  `TCW_ASSERT(a_copy_below_last, copy_we_r |-> (cp_wa_r < AW'(LAST_BASE)), "copy hit bottom row")
  `TCW_ASSERT(a_fill_bottom, (state_r == ST_FILL) |-> (cnt_r >= AW'(LAST_BASE)), "fill off bottom row")
  `TCW_ASSERT(a_no_double_pend, !((col_r == CW'(COLUMNS)) && (row_r == RW'(ROWS))), "wrap and scroll both pending")
  `TCW_ASSERT_ALWAYS(a_stall_blocks, (out_valid_r && !out_tready) |-> !in_tready, "accepted over stalled result")

endmodule

FILE: hdl/text_console_char_writer.sv
// Channel | Handshake           | Payload (low bit up)
// in      | in_tvalid/in_tready | tdata: char_code[7:0], attribute[15:8]
// out     | out_tvalid/out_tready | tdata: cell_index, cell_char, cell_attr, scrolled,
//         |                     |   cursor_col, cursor_row; tuser: cell_written
//
// An item without scroll is written directly; the result sits in an output register
// so the next item is taken while the previous result is being read.
// A scroll holds in_tready low while the screen memory reads one cell and writes
// it one row up per cycle, then clears the bottom row and writes any pending character into it.
// After reset a clearing pass zeroes the screen memory, with in_tready low throughout.
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,   // char_code, attribute
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,  // cell_index, cell_char, cell_attr,
                                                      // scrolled, cursor_col, cursor_row
  output logic [0:0]                      out_tuser   // cell_written
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);

  tcw_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_screen_mem #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
